// ===== hdl/segi_pkg.sv =====
// ----------------------------------------------------------------------------
// segi_pkg
// Shared constants and codes for the segment intersection block.
// ----------------------------------------------------------------------------
package segi_pkg;

  // default coordinate width and fixed width of the near-zero limit register
  localparam int COORD_BITS_DEF = 16;
  localparam int LIMIT_BITS     = 35;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH    = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  // width of one queue entry for a given coordinate width:
  // status, x0, y0, two signs, two magnitudes, z and n
  function automatic int entry_bits(input int cb);
    entry_bits = 2 + 2 * cb + 2 + 2 * cb + 2 * (2 * cb + 2);
  endfunction

endpackage

// ===== hdl/segment_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_intersection
// Exact 2D segment-segment intersection on signed integer coordinates.
//
//   channel | ports                      | direction
//   --------+----------------------------+----------
//   in      | in_valid/in_stall, 8 coords| into block
//   out     | out_valid/out_stall, status, cross_x, cross_y | out of block
//   cfg     | cfg_wr_en, cfg_wr_data     | into block
//
// One beat per cycle sustained while the output is not stalled; a beat passes the
// front stages, the queue, then the bit-per-stage divider and the output register.
// Reset (rst_n low, synchronous) empties all stages and the queue and clears
// the near-zero limit. A stalled output backs up the divider, then the
// queue, then the front; in_stall rises only once all of these are full.
// ----------------------------------------------------------------------------
module segment_intersection #(
  parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [segi_pkg::LIMIT_BITS-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_a_start_x,
  input  logic signed [COORD_BITS-1:0]        in_a_start_y,
  input  logic signed [COORD_BITS-1:0]        in_a_end_x,
  input  logic signed [COORD_BITS-1:0]        in_a_end_y,
  input  logic signed [COORD_BITS-1:0]        in_b_start_x,
  input  logic signed [COORD_BITS-1:0]        in_b_start_y,
  input  logic signed [COORD_BITS-1:0]        in_b_end_x,
  input  logic signed [COORD_BITS-1:0]        in_b_end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [COORD_BITS-1:0]        out_cross_x,
  output logic signed [COORD_BITS-1:0]        out_cross_y
);

  localparam int EW = segi_pkg::entry_bits(COORD_BITS);

  logic [segi_pkg::LIMIT_BITS-1:0] limit_r;
  logic          push, q_ready, pop, q_valid;
  logic [EW-1:0] push_data, pop_data;

  // near-zero limit register
  always_ff @(posedge clk) begin
    if (!rst_n)         limit_r <= '0;
    else if (cfg_wr_en) limit_r <= cfg_wr_data;
  end

  segi_front #(.CB(COORD_BITS), .EW(EW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .a_start_x (in_a_start_x),
    .a_start_y (in_a_start_y),
    .a_end_x   (in_a_end_x),
    .a_end_y   (in_a_end_y),
    .b_start_x (in_b_start_x),
    .b_start_y (in_b_start_y),
    .b_end_x   (in_b_end_x),
    .b_end_y   (in_b_end_y),
    .push      (push),
    .q_ready   (q_ready),
    .entry     (push_data)
  );

  segi_queue #(.EW(EW), .DEPTH(segi_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_data   (pop_data)
  );

  segi_back #(.CB(COORD_BITS), .EW(EW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (out_status),
    .cross_x   (out_cross_x),
    .cross_y   (out_cross_y)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != segi_pkg::ST_HIT) |->
      (out_cross_x == '0 && out_cross_y == '0))
    else $error("point not zero on a miss");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");
  a_limit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> $stable(limit_r))
    else $error("limit changed without a write");

endmodule

// ===== hdl/segi_front.sv =====
// ----------------------------------------------------------------------------
// segi_front
// Accepts segment pairs, forms the cross products and classifies each beat
// as hit, parallel or outside before handing it to the queue.
// ----------------------------------------------------------------------------
module segi_front #(
  parameter int CB = segi_pkg::COORD_BITS_DEF,
  parameter int EW = segi_pkg::entry_bits(CB)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [segi_pkg::LIMIT_BITS-1:0]  limit,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [CB-1:0]             a_start_x,
  input  logic signed [CB-1:0]             a_start_y,
  input  logic signed [CB-1:0]             a_end_x,
  input  logic signed [CB-1:0]             a_end_y,
  input  logic signed [CB-1:0]             b_start_x,
  input  logic signed [CB-1:0]             b_start_y,
  input  logic signed [CB-1:0]             b_end_x,
  input  logic signed [CB-1:0]             b_end_y,
  output logic                             push,
  input  logic                             q_ready,
  output logic [EW-1:0]                    entry
);

  localparam int D  = CB + 1;
  localparam int PB = 2 * D;
  localparam int NB = PB + 1;
  localparam int RB = NB - 1;
  localparam int LB = segi_pkg::LIMIT_BITS;
  localparam int CW = (NB > LB) ? NB : LB;

  // stage valids
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // stage 1: differences
  logic signed [CB-1:0] s1_x0_r, s1_y0_r;
  logic signed [D-1:0]  dx_r, dy_r, ex_r, ey_r, gx_r, gy_r;
  // stage 2: products
  logic signed [CB-1:0] s2_x0_r, s2_y0_r;
  logic signed [D-1:0]  s2_dx_r, s2_dy_r;
  logic signed [PB-1:0] p_dyex_r, p_dxey_r, p_gxey_r, p_gyex_r, p_gxdy_r, p_gydx_r;
  // stage 3: classified entry
  logic [EW-1:0]        entry_r, entry_nxt;

  // ready chain toward the input
  assign rdy3     = !v3_r || q_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign push     = v3_r && q_ready;
  assign entry    = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_x0_r <= a_start_x;
      s1_y0_r <= a_start_y;
      dx_r <= {a_end_x[CB-1], a_end_x} - {a_start_x[CB-1], a_start_x};
      dy_r <= {a_end_y[CB-1], a_end_y} - {a_start_y[CB-1], a_start_y};
      ex_r <= {b_end_x[CB-1], b_end_x} - {b_start_x[CB-1], b_start_x};
      ey_r <= {b_end_y[CB-1], b_end_y} - {b_start_y[CB-1], b_start_y};
      gx_r <= {a_start_x[CB-1], a_start_x} - {b_start_x[CB-1], b_start_x};
      gy_r <= {a_start_y[CB-1], a_start_y} - {b_start_y[CB-1], b_start_y};
    end
  end

  // stage 2 payload: six products
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_x0_r  <= s1_x0_r;
      s2_y0_r  <= s1_y0_r;
      s2_dx_r  <= dx_r;
      s2_dy_r  <= dy_r;
      p_dyex_r <= dy_r * ex_r;
      p_dxey_r <= dx_r * ey_r;
      p_gxey_r <= gx_r * ey_r;
      p_gyex_r <= gy_r * ex_r;
      p_gxdy_r <= gx_r * dy_r;
      p_gydx_r <= gy_r * dx_r;
    end
  end

  // stage 3: sums, sign normalization and classification
  logic signed [NB-1:0] nn, z, w, zn, wn;
  logic [NB-1:0]        nabs;
  logic                 par, outside;
  segi_pkg::status_t    status;
  logic [CB-1:0]        ax, ay;

  always_comb begin
    nn   = {p_dyex_r[PB-1], p_dyex_r} - {p_dxey_r[PB-1], p_dxey_r};
    z    = {p_gxey_r[PB-1], p_gxey_r} - {p_gyex_r[PB-1], p_gyex_r};
    w    = {p_gxdy_r[PB-1], p_gxdy_r} - {p_gydx_r[PB-1], p_gydx_r};
    nabs = nn[NB-1] ? NB'(-nn) : NB'(nn);
    zn   = nn[NB-1] ? -z : z;
    wn   = nn[NB-1] ? -w : w;
    par  = CW'(nabs) <= CW'(limit);
    outside = zn[NB-1] || (zn > $signed(nabs)) || wn[NB-1] || (wn > $signed(nabs));
    if (par)          status = segi_pkg::ST_PARALLEL;
    else if (outside) status = segi_pkg::ST_OUTSIDE;
    else              status = segi_pkg::ST_HIT;
    ax = s2_dx_r[D-1] ? CB'(-s2_dx_r) : CB'(s2_dx_r);
    ay = s2_dy_r[D-1] ? CB'(-s2_dy_r) : CB'(s2_dy_r);
    entry_nxt = {status, s2_x0_r, s2_y0_r, s2_dx_r[D-1], s2_dy_r[D-1], ax, ay,
                 zn[RB-1:0], nabs[RB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) entry_r <= entry_nxt;
  end

endmodule

// ===== hdl/segi_queue.sv =====
// ----------------------------------------------------------------------------
// segi_queue
// Short register queue that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
module segi_queue #(
  parameter int EW    = 8,
  parameter int DEPTH = segi_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [EW-1:0] push_data,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output logic [EW-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [EW-1:0]   mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;

  assign push_ready = count_r != CNTW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNTW'(DEPTH)) || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");

endmodule

// ===== hdl/segi_back.sv =====
// ----------------------------------------------------------------------------
// segi_back
// Pipelined scaled divider: one bit of |d| per stage gives floor(|d|*z/n)
// for both axes, then the point is placed and the result beat registered.
// ----------------------------------------------------------------------------
module segi_back #(
  parameter int CB = segi_pkg::COORD_BITS_DEF,
  parameter int EW = segi_pkg::entry_bits(CB)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [EW-1:0]        q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic signed [CB-1:0] cross_x,
  output logic signed [CB-1:0] cross_y
);

  localparam int NB = 2 * CB + 3;
  localparam int RB = NB - 1;
  localparam int NS = CB + 1;

  // one scaled-division step: r = 2r + bit*z, then remove up to two n
  function automatic logic [RB+CB-1:0] div_step(input logic [RB-1:0] r,
                                                input logic [CB-1:0] q,
                                                input logic          b,
                                                input logic [RB-1:0] zv,
                                                input logic [RB-1:0] nv);
    logic [RB+1:0] r2, n1, n2, rs;
    logic [CB-1:0] inc;
    r2 = {1'b0, r, 1'b0} + (b ? {2'b00, zv} : '0);
    n1 = {2'b00, nv};
    n2 = {1'b0, nv, 1'b0};
    if (r2 >= n2) begin
      rs  = r2 - n2;
      inc = CB'(2);
    end else if (r2 >= n1) begin
      rs  = r2 - n1;
      inc = CB'(1);
    end else begin
      rs  = r2;
      inc = '0;
    end
    div_step = {rs[RB-1:0], {q[CB-2:0], 1'b0} + inc};
  endfunction

  // stage registers
  logic [NS-1:0]        sv_r;
  logic [NS-1:0]        rdy;
  logic [1:0]           st_status [NS];
  logic [CB-1:0]        st_x0 [NS];
  logic [CB-1:0]        st_y0 [NS];
  logic                 st_sx [NS];
  logic                 st_sy [NS];
  logic [CB-1:0]        st_ax [NS];
  logic [CB-1:0]        st_ay [NS];
  logic [RB-1:0]        st_z  [NS];
  logic [RB-1:0]        st_n  [NS];
  logic [RB-1:0]        st_rx [NS];
  logic [RB-1:0]        st_ry [NS];
  logic [CB-1:0]        st_qx [NS];
  logic [CB-1:0]        st_qy [NS];
  logic                 out_valid_r;
  logic                 out_rdy;
  logic [1:0]           status_r;
  logic [CB-1:0]        cross_x_r, cross_y_r;

  assign out_rdy   = !out_valid_r || !out_stall;
  assign pop       = q_valid && rdy[0];
  assign out_valid = out_valid_r;
  assign status    = status_r;
  assign cross_x   = cross_x_r;
  assign cross_y   = cross_y_r;

  // ready chain from the output back to the queue
  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_rdy
      if (k == NS - 1) begin : g_last
        assign rdy[k] = !sv_r[k] || out_rdy;
      end else begin : g_mid
        assign rdy[k] = !sv_r[k] || rdy[k+1];
      end
    end
  endgenerate

  // stage valids and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) sv_r[0] <= q_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) sv_r[i] <= sv_r[i-1];
      end
      if (out_rdy) out_valid_r <= sv_r[NS-1];
    end
  end

  // load from the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      {st_status[0], st_x0[0], st_y0[0], st_sx[0], st_sy[0], st_ax[0], st_ay[0],
       st_z[0], st_n[0]} <= q_data;
      st_rx[0] <= '0;
      st_ry[0] <= '0;
      st_qx[0] <= '0;
      st_qy[0] <= '0;
    end
  end

  // division stages, stage k handles bit CB-1-k of each magnitude
  generate
    for (k = 0; k < NS - 1; k++) begin : g_stage
      logic [RB+CB-1:0] sx_nxt, sy_nxt;
      always_comb begin
        sx_nxt = div_step(st_rx[k], st_qx[k], st_ax[k][CB-1-k], st_z[k], st_n[k]);
        sy_nxt = div_step(st_ry[k], st_qy[k], st_ay[k][CB-1-k], st_z[k], st_n[k]);
      end
      always_ff @(posedge clk) begin
        if (rdy[k+1] && sv_r[k]) begin
          st_status[k+1] <= st_status[k];
          st_x0[k+1]     <= st_x0[k];
          st_y0[k+1]     <= st_y0[k];
          st_sx[k+1]     <= st_sx[k];
          st_sy[k+1]     <= st_sy[k];
          st_ax[k+1]     <= st_ax[k];
          st_ay[k+1]     <= st_ay[k];
          st_z[k+1]      <= st_z[k];
          st_n[k+1]      <= st_n[k];
          st_rx[k+1]     <= sx_nxt[RB+CB-1:CB];
          st_ry[k+1]     <= sy_nxt[RB+CB-1:CB];
          st_qx[k+1]     <= sx_nxt[CB-1:0];
          st_qy[k+1]     <= sy_nxt[CB-1:0];
        end
      end
    end
  endgenerate

  // place the point; zero unless hit
  logic          hit;
  logic [CB-1:0] px, py;
  always_comb begin
    hit = st_status[NS-1] == segi_pkg::ST_HIT;
    px  = st_sx[NS-1] ? st_x0[NS-1] - st_qx[NS-1] : st_x0[NS-1] + st_qx[NS-1];
    py  = st_sy[NS-1] ? st_y0[NS-1] - st_qy[NS-1] : st_y0[NS-1] + st_qy[NS-1];
  end

  always_ff @(posedge clk) begin
    if (out_rdy && sv_r[NS-1]) begin
      status_r  <= st_status[NS-1];
      cross_x_r <= hit ? px : '0;
      cross_y_r <= hit ? py : '0;
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for segment_intersection: directed corner pairs, then random
// segment pairs under random valid gaps and output stalls. A scoreboard
// predicts each accepted beat and checks results in order.
// ----------------------------------------------------------------------------

// scoreboard: predicts intersection results and checks them in order
class segi_scoreboard;
  typedef struct {
    segi_pkg::status_t status;
    logic signed [15:0] cross_x;
    logic signed [15:0] cross_y;
  } hit_t;

  hit_t pending[$];
  logic [34:0] near_zero_limit;
  int errors;

  function new();
    near_zero_limit = '0;
    errors = 0;
  endfunction

  // floor(a*z/n), z <= n
  function longint scaled_quot(longint a, longint z, longint n);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 17; i >= 0; i--) begin
      q = q << 1;
      r = r << 1;
      if ((a >> i) & 1) r += z;
      while (r >= n) begin
        r -= n;
        q++;
      end
    end
    return q;
  endfunction

  function longint along(longint base, longint d, longint z, longint n);
    longint q;
    q = scaled_quot(d < 0 ? -d : d, z, n);
    return d < 0 ? base - q : base + q;
  endfunction

  // note an accepted input beat
  function void note_pair(logic signed [15:0] c[8]);
    longint x0, y0, dx, dy, ex, ey, gx, gy, nn, z, w, an;
    hit_t h;
    x0 = c[0]; y0 = c[1];
    dx = longint'(c[2]) - x0; dy = longint'(c[3]) - y0;
    ex = longint'(c[6]) - c[4]; ey = longint'(c[7]) - c[5];
    gx = x0 - c[4]; gy = y0 - c[5];
    nn = dy * ex - dx * ey;
    z = gx * ey - gy * ex;
    w = gx * dy - gy * dx;
    h.cross_x = '0;
    h.cross_y = '0;
    an = nn < 0 ? -nn : nn;
    if (an <= longint'(near_zero_limit)) h.status = segi_pkg::ST_PARALLEL;
    else begin
      if (nn < 0) begin
        nn = -nn; z = -z; w = -w;
      end
      if (z < 0 || z > nn || w < 0 || w > nn) h.status = segi_pkg::ST_OUTSIDE;
      else begin
        h.status = segi_pkg::ST_HIT;
        h.cross_x = 16'(along(x0, dx, z, nn));
        h.cross_y = 16'(along(y0, dy, z, nn));
      end
    end
    pending.push_back(h);
  endfunction

  // check one result beat against the oldest prediction
  function void check_result(logic [1:0] st, logic [15:0] cx, logic [15:0] cy);
    hit_t h;
    if (pending.size() == 0) begin
      $error("unexpected result beat status=%0d", st);
      errors++;
      return;
    end
    h = pending.pop_front();
    if (st !== h.status) begin
      $error("status expected %0d actual %0d", h.status, st);
      errors++;
    end
    if (cx !== h.cross_x) begin
      $error("cross_x expected %0d actual %0d", h.cross_x, $signed(cx));
      errors++;
    end
    if (cy !== h.cross_y) begin
      $error("cross_y expected %0d actual %0d", h.cross_y, $signed(cy));
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int CB = 16;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [segi_pkg::LIMIT_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] coord[8];
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [CB-1:0] out_cross_x;
  logic signed [CB-1:0] out_cross_y;
  logic stim_done = 1'b0;
  longint cycles = 0;

  segi_scoreboard sb = new();

  initial for (int i = 0; i < 8; i++) coord[i] = '0;

  always #5 clk = ~clk;

  segment_intersection #(.COORD_BITS(CB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_start_x(coord[0]), .in_a_start_y(coord[1]),
    .in_a_end_x(coord[2]), .in_a_end_y(coord[3]),
    .in_b_start_x(coord[4]), .in_b_start_y(coord[5]),
    .in_b_end_x(coord[6]), .in_b_end_y(coord[7]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  // sample beats on both channels
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall) sb.note_pair(coord);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_cross_x, out_cross_y);
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_intersection regression: fail");
      $finish;
    end
  end

  // receiver stalls: random stretch per beat, some quiet phases
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stim_done || ($urandom_range(0, 3) == 0)) out_stall <= 1'b0;
      else begin
        n = $urandom_range(0, 9);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
      if (out_valid) @(posedge clk);
    end
  end

  // drive one beat, waiting a random gap first when gaps is set
  task automatic send_pair(logic signed [CB-1:0] v[8], bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    for (int i = 0; i < 8; i++) coord[i] <= v[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait for all results, then drain cycles, before a register write
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (CB + 10) @(negedge clk);
  endtask

  task automatic write_limit(logic [segi_pkg::LIMIT_BITS-1:0] v);
    settle();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.near_zero_limit = v;
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(int span);
    if (span == 0) return CB'($urandom);
    return CB'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  logic signed [CB-1:0] v[8];
  logic signed [CB-1:0] ext[4];
  logic [segi_pkg::LIMIT_BITS-1:0] lims[5];

  initial begin
    int span;
    bit gaps;
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    lims = '{35'h0, 35'h7_ffff_ffff, 35'd1000, 35'h4_0000_0000, 35'd3};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: crossing X, endpoint touch, parallel, zero length, outside
    v = '{-100, 0, 100, 0, 0, -100, 0, 100}; send_pair(v, 0);
    v = '{0, 0, 10, 10, 10, 10, 20, 0}; send_pair(v, 0);
    v = '{0, 0, 10, 0, 0, 5, 10, 5}; send_pair(v, 0);
    v = '{0, 0, 10, 0, 5, 0, 20, 0}; send_pair(v, 0);
    v = '{3, 3, 3, 3, 0, 0, 9, 9}; send_pair(v, 0);
    v = '{0, 0, 1, 1, 5, 0, 0, 5}; send_pair(v, 0);
    v = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}; send_pair(v, 0);
    v = '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}; send_pair(v, 0);
    v = '{-32768, 0, 32767, 1, 0, -32768, 1, 32767}; send_pair(v, 0);
    v = '{0, 0, 7, 3, 7, 3, 0, 0}; send_pair(v, 0);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 8; i++) v[i] = ext[$urandom_range(0, 3)];
      send_pair(v, 0);
    end

    // random phases across limit settings
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(lims[ph]);
      for (int k = 0; k < 380; k++) begin
        gaps = (k % 100) >= 30;
        span = (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 200 : 20000);
        if ($urandom_range(0, 9) < 6) begin
          // well-formed crossing: B straddles A around the midpoint of A
          v[0] = rnd_coord(span); v[1] = rnd_coord(span);
          v[2] = rnd_coord(span); v[3] = rnd_coord(span);
          v[4] = (v[0] + v[2]) / 2 + rnd_coord(span / 4 + 1);
          v[5] = (v[1] + v[3]) / 2 - rnd_coord(span / 4 + 1);
          v[6] = 2 * ((v[0] + v[2]) / 2) - v[4];
          v[7] = 2 * ((v[1] + v[3]) / 2) - v[5];
        end else
          for (int i = 0; i < 8; i++) v[i] = rnd_coord(span);
        send_pair(v, gaps);
      end
    end

    in_valid <= 1'b0;
    stim_done <= 1'b1;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (CB + 20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("segment_intersection regression: pass");
    else
      $display("segment_intersection regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/segi_pkg.sv
hdl/segi_front.sv
hdl/segi_queue.sv
hdl/segi_back.sv
hdl/segment_intersection.sv
bench/tb.sv
